/* rtl/nqfs_pkg.sv */
// ----------------------------------------------------------------------------
// N-queens first-solution search: shared definitions
// Sizes, widths, controller states and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package nqfs_pkg;

  localparam int MAX_SIZE   = 16;
  localparam int SIZE_LIMIT = (MAX_SIZE < 16) ? MAX_SIZE : 16;
  localparam int SIZE_W     = 5;
  localparam int FIELD_W    = 4;
  localparam int ROW_W      = $clog2(SIZE_LIMIT);
  localparam int CNT_W      = $clog2(SIZE_LIMIT + 1);
  localparam int DIAG_N     = 2 * SIZE_LIMIT - 1;
  localparam int DIAG_W     = $clog2(DIAG_N);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_BT_APPLY,
    ST_EMIT_READ,
    ST_EMIT_LOAD,
    ST_OUT
  } nqfs_state_e;

  typedef struct packed {
    logic start;
    logic place;
    logic advance;
    logic bt_read;
    logic bt_apply;
    logic emit_start;
    logic load_result;
    logic load_fail;
    logic emit_next;
  } nqfs_cmd_t;

  typedef struct packed {
    logic size_ok;
    logic row_full;
    logic col_full;
    logic row_zero;
    logic square_free;
    logic out_last;
  } nqfs_status_t;

endpackage

/* rtl/nqfs_ctrl.sv */
// ----------------------------------------------------------------------------
// N-queens first-solution search: controller
// Sequences the search, the backtracking and the emission of result words.
// ----------------------------------------------------------------------------
module nqfs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  nqfs_pkg::nqfs_status_t status_i,
  output nqfs_pkg::nqfs_cmd_t    cmd_o
);

  nqfs_pkg::nqfs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nqfs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      nqfs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.size_ok ? nqfs_pkg::ST_SEARCH : nqfs_pkg::ST_OUT;
        end
      end
      nqfs_pkg::ST_SEARCH: begin
        if (status_i.row_full) begin
          state_d = nqfs_pkg::ST_EMIT_READ;
        end else if (status_i.col_full) begin
          state_d = status_i.row_zero ? nqfs_pkg::ST_OUT : nqfs_pkg::ST_BT_APPLY;
        end
      end
      nqfs_pkg::ST_BT_APPLY:  state_d = nqfs_pkg::ST_SEARCH;
      nqfs_pkg::ST_EMIT_READ: state_d = nqfs_pkg::ST_EMIT_LOAD;
      nqfs_pkg::ST_EMIT_LOAD: state_d = nqfs_pkg::ST_OUT;
      nqfs_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = status_i.out_last ? nqfs_pkg::ST_IDLE : nqfs_pkg::ST_EMIT_READ;
        end
      end
      default: state_d = nqfs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      nqfs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start     = status_i.size_ok;
          cmd_o.load_fail = !status_i.size_ok;
        end
      end
      nqfs_pkg::ST_SEARCH: begin
        if (status_i.row_full) begin
          cmd_o.emit_start = 1'b1;
        end else if (status_i.col_full) begin
          cmd_o.load_fail = status_i.row_zero;
          cmd_o.bt_read   = !status_i.row_zero;
        end else if (status_i.square_free) begin
          cmd_o.place = 1'b1;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      nqfs_pkg::ST_BT_APPLY:  cmd_o.bt_apply = 1'b1;
      nqfs_pkg::ST_EMIT_READ: ;
      nqfs_pkg::ST_EMIT_LOAD: cmd_o.load_result = 1'b1;
      nqfs_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.emit_next = out_ready_i && !status_i.out_last;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/nqfs_datapath.sv */
// ----------------------------------------------------------------------------
// N-queens first-solution search: datapath
// Holds the placed-column stack, the occupancy masks for columns and both
// diagonals, the search counters and the result word register.
// ----------------------------------------------------------------------------
module nqfs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [nqfs_pkg::SIZE_W-1:0]   board_size_i,
  input  nqfs_pkg::nqfs_cmd_t           cmd_i,
  output nqfs_pkg::nqfs_status_t        status_o,
  output logic [nqfs_pkg::FIELD_W-1:0]  row_index_o,
  output logic [nqfs_pkg::FIELD_W-1:0]  queen_column_o,
  output logic                          solved_o,
  output logic                          last_row_o
);

  logic [nqfs_pkg::ROW_W-1:0]     stack_mem [nqfs_pkg::SIZE_LIMIT];
  logic [nqfs_pkg::ROW_W-1:0]     rd_data_q;
  logic [nqfs_pkg::ROW_W-1:0]     rd_addr;

  logic [nqfs_pkg::CNT_W-1:0]     size_q;
  logic [nqfs_pkg::CNT_W-1:0]     row_q, row_d;
  logic [nqfs_pkg::CNT_W-1:0]     col_q, col_d;
  logic [nqfs_pkg::CNT_W-1:0]     emit_q, emit_d;
  logic [nqfs_pkg::SIZE_LIMIT-1:0] col_mask_q;
  logic [nqfs_pkg::DIAG_N-1:0]    sum_mask_q;
  logic [nqfs_pkg::DIAG_N-1:0]    dif_mask_q;

  logic [nqfs_pkg::FIELD_W-1:0]   row_index_q;
  logic [nqfs_pkg::FIELD_W-1:0]   queen_column_q;
  logic                           solved_q;
  logic                           last_row_q;

  logic [nqfs_pkg::ROW_W-1:0]     row_lo;
  logic [nqfs_pkg::ROW_W-1:0]     col_lo;
  logic [nqfs_pkg::ROW_W-1:0]     mark_col;
  logic [nqfs_pkg::DIAG_W-1:0]    sum_idx;
  logic [nqfs_pkg::DIAG_W-1:0]    dif_idx;
  logic                           emit_last;

  assign row_lo   = row_q[nqfs_pkg::ROW_W-1:0];
  assign col_lo   = col_q[nqfs_pkg::ROW_W-1:0];
  assign mark_col = cmd_i.bt_apply ? rd_data_q : col_lo;
  assign sum_idx  = nqfs_pkg::DIAG_W'(row_lo) + nqfs_pkg::DIAG_W'(mark_col);
  assign dif_idx  = nqfs_pkg::DIAG_W'(row_lo) + nqfs_pkg::DIAG_W'(nqfs_pkg::SIZE_LIMIT - 1)
                  - nqfs_pkg::DIAG_W'(mark_col);
  assign rd_addr  = cmd_i.bt_read ? row_d[nqfs_pkg::ROW_W-1:0]
                                  : emit_q[nqfs_pkg::ROW_W-1:0];
  assign emit_last = (emit_q + nqfs_pkg::CNT_W'(1)) == size_q;

  always_comb begin
    status_o.size_ok     = (board_size_i != '0) &&
                           (board_size_i <= nqfs_pkg::SIZE_W'(nqfs_pkg::SIZE_LIMIT));
    status_o.row_full    = row_q == size_q;
    status_o.col_full    = col_q == size_q;
    status_o.row_zero    = row_q == '0;
    status_o.square_free = !col_mask_q[col_lo] && !sum_mask_q[sum_idx] && !dif_mask_q[dif_idx];
    status_o.out_last    = last_row_q;
  end

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    emit_d = emit_q;
    if (cmd_i.start) begin
      row_d = '0;
      col_d = '0;
    end else if (cmd_i.place) begin
      row_d = row_q + nqfs_pkg::CNT_W'(1);
      col_d = '0;
    end else if (cmd_i.advance) begin
      col_d = col_q + nqfs_pkg::CNT_W'(1);
    end else if (cmd_i.bt_read) begin
      row_d = row_q - nqfs_pkg::CNT_W'(1);
    end else if (cmd_i.bt_apply) begin
      col_d = nqfs_pkg::CNT_W'(rd_data_q) + nqfs_pkg::CNT_W'(1);
    end
    if (cmd_i.emit_start) begin
      emit_d = '0;
    end else if (cmd_i.emit_next) begin
      emit_d = emit_q + nqfs_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      emit_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      emit_q <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.place) begin
      stack_mem[row_lo] <= col_lo;
    end
    rd_data_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      size_q     <= board_size_i[nqfs_pkg::CNT_W-1:0];
      col_mask_q <= '0;
      sum_mask_q <= '0;
      dif_mask_q <= '0;
    end else if (cmd_i.place || cmd_i.bt_apply) begin
      col_mask_q[mark_col] <= cmd_i.place;
      sum_mask_q[sum_idx]  <= cmd_i.place;
      dif_mask_q[dif_idx]  <= cmd_i.place;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_fail) begin
      row_index_q    <= '0;
      queen_column_q <= '0;
      solved_q       <= 1'b0;
      last_row_q     <= 1'b1;
    end else if (cmd_i.load_result) begin
      row_index_q    <= nqfs_pkg::FIELD_W'(emit_q);
      queen_column_q <= nqfs_pkg::FIELD_W'(rd_data_q);
      solved_q       <= 1'b1;
      last_row_q     <= emit_last;
    end
  end

  assign row_index_o    = row_index_q;
  assign queen_column_o = queen_column_q;
  assign solved_o       = solved_q;
  assign last_row_o     = last_row_q;

endmodule

/* rtl/n_queens_first_solution_search_top.sv */
// ----------------------------------------------------------------------------
// N-queens first-solution search: top level
// Takes a board size and returns the first placement found by a depth-first
// search, one word per row.
// ----------------------------------------------------------------------------
// A request word carries a board size from 1 to 16; the block then searches
// rows in order and columns in ascending order, trying one column at a time
// and stepping back to an earlier row through a read of the column stack and
// a clearing of that queen's masks, resuming at the next column. Each result
// word then passes through a stack read, a load of the result register and
// the output state, where it waits for the output side. Sizes of zero, above
// 16, and the unsolvable sizes 2 and 3 give a single word with solved cleared.
// A new request is taken only after the final word of a run has been accepted.
module n_queens_first_solution_search_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [nqfs_pkg::SIZE_W-1:0]  board_size_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [nqfs_pkg::FIELD_W-1:0] row_index_o,
  output logic [nqfs_pkg::FIELD_W-1:0] queen_column_o,
  output logic                         solved_o,
  output logic                         last_row_o
);

  nqfs_pkg::nqfs_cmd_t    cmd;
  nqfs_pkg::nqfs_status_t status;

  nqfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nqfs_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .board_size_i   (board_size_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .row_index_o    (row_index_o),
    .queen_column_o (queen_column_o),
    .solved_o       (solved_o),
    .last_row_o     (last_row_o)
  );

endmodule
